[sv/fsmix_pkg.sv]
// Shared types and constants of the flaperon servo mixer.
package fsmix_pkg;

    // servo axes: left flaperon, right flaperon, rudder
    localparam int NSERVO    = 3;
    localparam int HIST_TAPS = 4;

    // mixer choice
    localparam logic [1:0] MODE_STAB   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_SPORT  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SCALE_ROLL    = 3'd0;
    localparam logic [2:0] CFG_SCALE_PITCH   = 3'd1;
    localparam logic [2:0] CFG_SCALE_YAW     = 3'd2;
    localparam logic [2:0] CFG_SUBTRIM_ROLL  = 3'd3;
    localparam logic [2:0] CFG_SUBTRIM_PITCH = 3'd4;
    localparam logic [2:0] CFG_SUBTRIM_YAW   = 3'd5;
    localparam logic [2:0] CFG_INVERT_MASK   = 3'd6;
    localparam logic [2:0] CFG_BOOST_FACTOR  = 3'd7;

    localparam logic [31:0] SCALE_RESET = 32'h4000_4000;
    localparam logic [14:0] THR_MAX     = 15'd16384;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [15:0] pid_roll;
        logic signed [15:0] pid_pitch;
        logic signed [15:0] pid_yaw;
        logic signed [15:0] stick_roll;
        logic signed [15:0] stick_pitch;
        logic signed [15:0] stick_yaw;
        logic        [14:0] throttle_in;
        logic signed [15:0] trim_roll;
        logic signed [15:0] trim_pitch;
        logic signed [15:0] trim_yaw;
    } t_item;

    typedef struct packed {
        logic signed [15:0] flaperon_left;
        logic signed [15:0] flaperon_right;
        logic signed [15:0] rudder;
        logic        [14:0] throttle_out;
    } t_result;

endpackage

[sv/fsmix_in_if.sv]
// Input channel of the flaperon servo mixer.
interface fsmix_in_if;
    import fsmix_pkg::*;

    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/fsmix_out_if.sv]
// Result channel of the flaperon servo mixer.
interface fsmix_out_if;
    import fsmix_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/flaperon_servo_mixer_top.sv]
// Each servo axis passes in turn through S_MIX, S_SCALE, S_POST, S_BOOST and S_FINAL;
// an axis at or beyond AXES skips S_BOOST. A new transaction is taken only in S_IDLE,
// so one is finished before the next is accepted; the single shared multiplier serves
// the scaling and the boost of the three axes in turn (up to five steps per axis).
// Reset (synchronous, active low) restores the register defaults, clears the boost
// history and empties the result register; no clearing pass is needed.
module flaperon_servo_mixer_top #(
    parameter int AXES = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [31:0]             i_cfg_data,
    fsmix_in_if.sink                i_item,
    fsmix_out_if.source             o_res
);
    import fsmix_pkg::*;

    localparam int HIST_ROWS  = (AXES < NSERVO) ? AXES : NSERVO;
    localparam int HIST_IDX_W = (HIST_ROWS > 1) ? $clog2(HIST_ROWS) : 1;
    localparam logic [2:0] AXES_LIM = 3'(AXES);

    localparam logic signed [23:0] HALF16 = 24'sd32768;
    localparam logic signed [23:0] ONE16  = 24'sd65536;
    localparam logic signed [23:0] ONE14  = 24'sd16384;

    typedef enum logic [2:0] {
        S_IDLE, S_MIX, S_SCALE, S_POST, S_BOOST, S_FINAL, S_DONE
    } t_state;

    function automatic logic signed [23:0] sx24(input logic signed [15:0] x);
        return {{8{x[15]}}, x};
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
        if (x > 24'sd32767) begin
            return 16'sh7fff;
        end else if (x < -24'sd32768) begin
            return 16'sh8000;
        end else begin
            return x[15:0];
        end
    endfunction

    t_state             r_state;
    logic [1:0]         r_axis;
    t_item              r_in;
    logic signed [20:0] r_d;
    logic [15:0]        r_scl;
    logic signed [37:0] r_prod;
    logic signed [15:0] r_q;
    logic signed [20:0] r_s;
    logic signed [15:0] r_res [NSERVO];
    logic               r_out_valid;
    t_result            r_out;

    logic [31:0]        r_scale [NSERVO];
    logic signed [15:0] r_subtrim [NSERVO];
    logic [2:0]         r_invert;
    logic [14:0]        r_boost;
    logic signed [15:0] r_hist [HIST_ROWS][HIST_TAPS];

    // per-axis datapath
    logic                  boost_en;
    logic [HIST_IDX_W-1:0] hidx;
    logic signed [23:0]    pr2, pp2, py4, sr, sp, sy;
    logic signed [23:0]    trim, lo, hi, ctr, mix, vclip, dd;
    logic signed [37:0]    sc_full, bst_full;
    logic signed [23:0]    vpost;
    logic signed [15:0]    q;
    logic signed [23:0]    s_sum;
    logic signed [23:0]    bst;
    logic signed [15:0]    res;

    // shared multiplier
    logic signed [20:0]    mul_a;
    logic [15:0]           mul_b;
    logic signed [37:0]    mul_p;

    assign boost_en = ({1'b0, r_axis} < AXES_LIM);
    assign hidx     = r_axis[HIST_IDX_W-1:0];

    always_comb begin
        pr2 = sx24(r_in.pid_roll) <<< 1;
        pp2 = sx24(r_in.pid_pitch) <<< 1;
        py4 = sx24(r_in.pid_yaw) <<< 2;
        sr  = sx24(r_in.stick_roll);
        sp  = sx24(r_in.stick_pitch);
        sy  = sx24(r_in.stick_yaw);

        case (r_axis)
            2'd0: begin
                trim = sx24(r_in.trim_roll);
                case (r_in.mode)
                    MODE_MANUAL: mix = sr + sp + HALF16;
                    MODE_SPORT:  mix = ((sr + ONE14) <<< 1) + pr2 + pp2;
                    default:     mix = (trim <<< 1) + HALF16 + pr2 + pp2;
                endcase
            end
            2'd1: begin
                trim = sx24(r_in.trim_pitch);
                case (r_in.mode)
                    MODE_MANUAL: mix = sr - sp + HALF16;
                    MODE_SPORT:  mix = ((sp + ONE14) <<< 1) + pr2 - pp2;
                    default:     mix = (trim <<< 1) + HALF16 + pr2 - pp2;
                endcase
            end
            default: begin
                trim = sx24(r_in.trim_yaw);
                case (r_in.mode)
                    MODE_MANUAL: mix = (sy + ONE14) <<< 1;
                    default:     mix = ((sy + ONE14) <<< 1) + py4;
                endcase
            end
        endcase

        lo  = trim <<< 1;
        hi  = lo + ONE16;
        ctr = lo + HALF16;
        if (mix < lo) begin
            vclip = lo;
        end else if (mix > hi) begin
            vclip = hi;
        end else begin
            vclip = mix;
        end
        dd = vclip - ctr;

        // scale about the centre, add half the subtrim, invert if selected
        sc_full = (r_prod + 38'sd8192) >>> 14;
        vpost   = ctr + sc_full[23:0] + (sx24(r_subtrim[r_axis]) <<< 1);
        if (r_invert[r_axis]) begin
            vpost = ONE16 - vpost;
        end
        q = sat16((vpost + 24'sd2) >>> 2);

        s_sum = (sx24(q) <<< 1) + (sx24(r_hist[hidx][0]) <<< 2)
              - (sx24(r_hist[hidx][2]) <<< 2) - (sx24(r_hist[hidx][3]) <<< 1);

        bst_full = (r_prod + 38'sd131072) >>> 18;
        bst      = boost_en ? bst_full[23:0] : 24'sd0;
        res      = sat16(sx24(r_q) + bst);
    end

    always_comb begin
        if (r_state == S_BOOST) begin
            mul_a = r_s;
            mul_b = {1'b0, r_boost};
        end else begin
            mul_a = r_d;
            mul_b = r_scl;
        end
        mul_p = 38'(mul_a) * 38'($signed({1'b0, mul_b}));
    end

    assign i_item.ready  = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
            r_invert    <= 3'd0;
            r_boost     <= 15'd0;
            for (int i = 0; i < NSERVO; i++) begin
                r_scale[i]   <= SCALE_RESET;
                r_subtrim[i] <= 16'sd0;
            end
            for (int i = 0; i < HIST_ROWS; i++) begin
                for (int k = 0; k < HIST_TAPS; k++) begin
                    r_hist[i][k] <= 16'sd0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCALE_ROLL:    r_scale[0]   <= i_cfg_data;
                    CFG_SCALE_PITCH:   r_scale[1]   <= i_cfg_data;
                    CFG_SCALE_YAW:     r_scale[2]   <= i_cfg_data;
                    CFG_SUBTRIM_ROLL:  r_subtrim[0] <= i_cfg_data[15:0];
                    CFG_SUBTRIM_PITCH: r_subtrim[1] <= i_cfg_data[15:0];
                    CFG_SUBTRIM_YAW:   r_subtrim[2] <= i_cfg_data[15:0];
                    CFG_INVERT_MASK:   r_invert     <= i_cfg_data[2:0];
                    CFG_BOOST_FACTOR:  r_boost      <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            // S_DONE decides the result register on its own
            if (r_out_valid && o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_in    <= i_item.payload;
                        r_axis  <= 2'd0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_d     <= dd[20:0];
                    r_scl   <= (dd > 24'sd0) ? r_scale[r_axis][31:16] : r_scale[r_axis][15:0];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= mul_p;
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_q     <= q;
                    r_s     <= s_sum[20:0];
                    r_state <= boost_en ? S_BOOST : S_FINAL;
                end
                S_BOOST: begin
                    r_prod  <= mul_p;
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_res[r_axis] <= res;
                    // shift the history, newest pre-boost value into tap 0
                    if (boost_en) begin
                        for (int k = HIST_TAPS - 1; k > 0; k--) begin
                            r_hist[hidx][k] <= r_hist[hidx][k-1];
                        end
                        r_hist[hidx][0] <= r_q;
                    end
                    if (r_axis == 2'(NSERVO - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_MIX;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid          <= 1'b1;
                        r_out.flaperon_left  <= r_res[0];
                        r_out.flaperon_right <= r_res[1];
                        r_out.rudder         <= r_res[2];
                        r_out.throttle_out   <= (r_in.throttle_in > THR_MAX) ?
                                                THR_MAX : r_in.throttle_in;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == S_MIX && r_axis == 2'd0))
        else $error("accepted transaction did not start at the first axis");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_axis < 2'(NSERVO)))
        else $error("axis counter out of range");

    a_boost_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BOOST) |-> ({1'b0, r_axis} < AXES_LIM))
        else $error("boost step on an axis without history");

    a_last_axis_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && r_axis == 2'(NSERVO - 1)) |=> (r_state == S_DONE))
        else $error("sequencer did not finish after the last axis");

    a_thr_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.throttle_out <= THR_MAX))
        else $error("throttle result above one");

endmodule

[test/flaperon_servo_mixer_top_tb.sv]
// Self-checking testbench of the flaperon servo mixer: directed table, then random traffic.
module flaperon_servo_mixer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsmix_pkg::*;

    localparam int         AXES          = 3;
    localparam int         CLK_PERIOD    = 10;
    localparam int         RESET_CYCLES  = 7;
    localparam int         NUM_SEGMENTS  = 6;
    localparam int         SEGMENT_ITEMS = 138;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         MAX_PRINTED   = 40;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam longint     UNIT_Q14      = 16384;
    localparam longint     HALF_Q16      = 32768;
    localparam longint     ONE_Q16       = 65536;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        t_item       item;
        bit          typed;
        t_result     want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    fsmix_in_if  in_ch ();
    fsmix_out_if out_ch ();

    flaperon_servo_mixer_top #(
        .AXES (AXES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch),
        .o_res      (out_ch)
    );

    // mirror of the block's registers and boost history
    logic [31:0]        scale_cfg   [NSERVO]            = '{default: SCALE_RESET};
    logic signed [15:0] subtrim_cfg [NSERVO]            = '{default: '0};
    logic [2:0]         invert_cfg                      = '0;
    logic [14:0]        boost_gain                      = '0;
    logic signed [15:0] boost_hist  [NSERVO][HIST_TAPS] = '{default: '{default: '0}};

    t_result  pending_servo [$];
    t_dir_row dir_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count     = 0;
    int n_items       = 0;
    int n_directed    = 0;
    int n_results     = 0;
    int n_writes      = 0;
    int cycle_count   = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat_q14(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Mix, clip, scale, trim, invert and boost one transaction; advances the history.
    function automatic t_result mix_servos(t_item it);
        longint  pr, pp, py, sr, sp, sy, thr;
        longint  v, lo, hi, ctr, q, s, boost, gain, pos_gain, neg_gain, sub;
        longint  trim [NSERVO];
        longint  mix  [NSERVO];
        int      i, k;
        t_result r;
        pr      = $signed(it.pid_roll);
        pp      = $signed(it.pid_pitch);
        py      = $signed(it.pid_yaw);
        sr      = $signed(it.stick_roll);
        sp      = $signed(it.stick_pitch);
        sy      = $signed(it.stick_yaw);
        thr     = it.throttle_in;
        trim[0] = $signed(it.trim_roll);
        trim[1] = $signed(it.trim_pitch);
        trim[2] = $signed(it.trim_yaw);
        gain    = boost_gain;
        r       = '0;
        case (it.mode)
            MODE_MANUAL: begin
                mix[0] = sr + sp + HALF_Q16;
                mix[1] = sr - sp + HALF_Q16;
                mix[2] = (sy + UNIT_Q14) * 2;
            end
            MODE_SPORT: begin
                mix[0] = (sr + UNIT_Q14) * 2 + pr * 2 + pp * 2;
                mix[1] = (sp + UNIT_Q14) * 2 + pr * 2 - pp * 2;
                mix[2] = (sy + UNIT_Q14) * 2 + py * 4;
            end
            default: begin
                // the undefined mode falls back to the stabilised mixer
                mix[0] = trim[0] * 2 + HALF_Q16 + pr * 2 + pp * 2;
                mix[1] = trim[1] * 2 + HALF_Q16 + pr * 2 - pp * 2;
                mix[2] = (sy + UNIT_Q14) * 2 + py * 4;
            end
        endcase
        for (i = 0; i < NSERVO; i++) begin
            pos_gain = scale_cfg[i][31:16];
            neg_gain = scale_cfg[i][15:0];
            sub      = subtrim_cfg[i];
            lo       = trim[i] * 2;
            hi       = lo + ONE_Q16;
            ctr      = lo + HALF_Q16;
            v        = mix[i];
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            if (v > ctr) v = ctr + round_q((v - ctr) * pos_gain, 14);
            else if (v < ctr) v = ctr + round_q((v - ctr) * neg_gain, 14);
            v = v + sub * 2;
            if (invert_cfg[i]) v = ONE_Q16 - v;
            q = sat_q14(round_q(v, 2));
            if (i < AXES) begin
                s = 2 * q + 4 * boost_hist[i][0] - 4 * boost_hist[i][2]
                  - 2 * boost_hist[i][3];
                boost = round_q(s * gain, 18);
                // history shifts even with the boost switched off
                for (k = HIST_TAPS - 1; k > 0; k--) boost_hist[i][k] = boost_hist[i][k - 1];
                boost_hist[i][0] = 16'(q);
                q = sat_q14(q + boost);
            end
            case (i)
                0:       r.flaperon_left  = 16'(q);
                1:       r.flaperon_right = 16'(q);
                default: r.rudder         = 16'(q);
            endcase
        end
        if (thr > UNIT_Q14) thr = UNIT_Q14;
        r.throttle_out = 15'(thr);
        return r;
    endfunction

    function automatic t_item mk(logic [1:0] m, int pr, int pp, int py, int sr, int sp,
                                 int sy, int thr, int tr, int tp, int ty);
        t_item it;
        it.mode        = m;
        it.pid_roll    = 16'(pr);
        it.pid_pitch   = 16'(pp);
        it.pid_yaw     = 16'(py);
        it.stick_roll  = 16'(sr);
        it.stick_pitch = 16'(sp);
        it.stick_yaw   = 16'(sy);
        it.throttle_in = 15'(thr);
        it.trim_roll   = 16'(tr);
        it.trim_pitch  = 16'(tp);
        it.trim_yaw    = 16'(ty);
        return it;
    endfunction

    function automatic t_result res(int l, int r, int y, int thr);
        t_result x;
        x.flaperon_left  = 16'(l);
        x.flaperon_right = 16'(r);
        x.rudder         = 16'(y);
        x.throttle_out   = 15'(thr);
        return x;
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [31:0] data);
        dir_rows.push_back('{1'b1, idx, data, '0, 1'b0, '0});
    endfunction

    function automatic void add_item(t_item it);
        dir_rows.push_back('{1'b0, '0, '0, it, 1'b0, '0});
    endfunction

    function automatic void add_chk(t_item it, t_result want);
        dir_rows.push_back('{1'b0, '0, '0, it, 1'b1, want});
    endfunction

    function automatic logic [15:0] rand_pid();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'(int'($urandom_range(16000)) - 8000);
        endcase
    endfunction

    function automatic logic [15:0] rand_unit();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: return 16'(int'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(32768, 4096));
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.mode        = ($urandom_range(15) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
        it.pid_roll    = rand_pid();
        it.pid_pitch   = rand_pid();
        it.pid_yaw     = rand_pid();
        it.stick_roll  = rand_unit();
        it.stick_pitch = rand_unit();
        it.stick_yaw   = rand_unit();
        it.throttle_in = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
        it.trim_roll   = rand_unit();
        it.trim_pitch  = rand_unit();
        it.trim_yaw    = rand_unit();
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SCALE_ROLL:    scale_cfg[0]   = data;
            CFG_SCALE_PITCH:   scale_cfg[1]   = data;
            CFG_SCALE_YAW:     scale_cfg[2]   = data;
            CFG_SUBTRIM_ROLL:  subtrim_cfg[0] = data[15:0];
            CFG_SUBTRIM_PITCH: subtrim_cfg[1] = data[15:0];
            CFG_SUBTRIM_YAW:   subtrim_cfg[2] = data[15:0];
            CFG_INVERT_MASK:   invert_cfg     = data[2:0];
            CFG_BOOST_FACTOR:  boost_gain     = data[14:0];
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_servo.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_item(t_item it, bit typed, t_result want);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = mix_servos(it);
        pending_servo.push_back(typed ? want : pred);
        n_items++;
    endtask

    task automatic apply_segment_config(int seg);
        logic [31:0] sc [NSERVO];
        logic [31:0] st [NSERVO];
        logic [31:0] inv;
        logic [31:0] gain;
        int          a;
        case (seg)
            0: begin
                sc   = '{default: 32'h0000_0000};
                st   = '{default: 32'hFFFF_C000};
                inv  = 32'd5;
                gain = 32'h0000_7FFF;
            end
            1: begin
                sc   = '{default: 32'hFFFF_FFFF};
                st   = '{default: 32'h0000_4000};
                inv  = 32'd2;
                gain = 32'd1;
            end
            2: begin
                sc   = '{default: SCALE_RESET};
                st   = '{default: 32'h0};
                inv  = 32'd0;
                gain = 32'd0;
            end
            default: begin
                // upper bits carry noise that the block must drop
                for (a = 0; a < NSERVO; a++) begin
                    sc[a] = {rand_scale(), rand_scale()};
                    st[a] = {16'($urandom), 16'(int'($urandom_range(32768)) - 16384)};
                end
                inv  = {29'($urandom), 3'($urandom_range(7))};
                gain = {17'($urandom),
                        ($urandom_range(3) == 0) ? 15'd0 : 15'($urandom_range(32767))};
            end
        endcase
        write_reg(CFG_SCALE_ROLL, sc[0]);
        write_reg(CFG_SCALE_PITCH, sc[1]);
        write_reg(CFG_SCALE_YAW, sc[2]);
        write_reg(CFG_SUBTRIM_ROLL, st[0]);
        write_reg(CFG_SUBTRIM_PITCH, st[1]);
        write_reg(CFG_SUBTRIM_YAW, st[2]);
        write_reg(CFG_INVERT_MASK, inv);
        write_reg(CFG_BOOST_FACTOR, gain);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            n_results++;
            if (pending_servo.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing outstanding", n_results));
            end else begin
                want = pending_servo.pop_front();
                if (got.flaperon_left !== want.flaperon_left)
                    report_mismatch($sformatf("result %0d flaperon_left %0d, want %0d",
                        n_results, got.flaperon_left, want.flaperon_left));
                if (got.flaperon_right !== want.flaperon_right)
                    report_mismatch($sformatf("result %0d flaperon_right %0d, want %0d",
                        n_results, got.flaperon_right, want.flaperon_right));
                if (got.rudder !== want.rudder)
                    report_mismatch($sformatf("result %0d rudder %0d, want %0d",
                        n_results, got.rudder, want.rudder));
                if (got.throttle_out !== want.throttle_out)
                    report_mismatch($sformatf("result %0d throttle_out %0d, want %0d",
                        n_results, got.throttle_out, want.throttle_out));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, pending_servo.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_item it;
        t_item last_it;
        int    seg;
        int    n;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 23;
        recv_idle_pct  = 56;

        // reset defaults: unit scales, no subtrim, no inversion, no boost
        add_chk(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), res(8192, 8192, 8192, 0));
        add_chk(mk(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), res(8192, 8192, 8192, 0));
        add_chk(mk(MODE_MANUAL, 0, 0, 0, 16384, 16384, 16384, 32767, 0, 0, 0),
                res(16384, 8192, 16384, 16384));
        add_chk(mk(MODE_SPORT, 0, 0, 0, -16384, -16384, -16384, 16384, 0, 0, 0),
                res(0, 0, 0, 16384));
        add_chk(mk(MODE_STAB, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0),
                res(16384, 8192, 16384, 0));
        add_chk(mk(MODE_STAB, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0),
                res(0, 8192, 0, 0));
        add_chk(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 0, 16384, 16384, 16384),
                res(16384, 16384, 8192, 0));
        add_chk(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 0, -16384, -16384, -16384),
                res(0, 0, 8192, 0));
        add_chk(mk(MODE_MANUAL, 0, 0, 0, 16384, -16384, 0, 0, 0, 0, 0),
                res(8192, 16384, 8192, 0));
        add_chk(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 16385, 0, 0, 0), res(8192, 8192, 8192, 16384));
        add_item(mk(MODE_MANUAL, 0, 0, 0, 32767, -32768, -32768, 0, 0, 0, 0));
        add_item(mk(MODE_SPORT, 1234, -777, -4000, 5000, -3000, 100, 9000, 2000, -1500, 700));
        // uneven scales: widest, zero and four-to-one
        add_cfg(CFG_SCALE_ROLL, 32'hFFFF_FFFF);
        add_cfg(CFG_SCALE_PITCH, 32'h0000_0000);
        add_cfg(CFG_SCALE_YAW, 32'h8000_2000);
        add_item(mk(MODE_STAB, 8000, 4000, 3000, 0, 0, 0, 4000, 0, 0, 0));
        add_item(mk(MODE_STAB, -8000, -4000, -3000, 0, 0, 0, 4000, 0, 0, 0));
        add_chk(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), res(8192, 8192, 8192, 0));
        // subtrim extremes drive the pre-boost value into saturation
        add_cfg(CFG_SUBTRIM_ROLL, 32'h0000_4000);
        add_cfg(CFG_SUBTRIM_PITCH, 32'hFFFF_C000);
        add_cfg(CFG_SUBTRIM_YAW, 32'h0000_4000);
        add_item(mk(MODE_STAB, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(MODE_STAB, -32768, 0, -20000, 0, 0, 0, 0, 0, 0, 0));
        add_cfg(CFG_INVERT_MASK, 32'd7);
        add_cfg(CFG_SUBTRIM_ROLL, 32'hFFFF_C000);
        add_item(mk(MODE_STAB, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(MODE_MANUAL, 0, 0, 0, 6000, -2500, 9000, 16384, 1000, -1000, 500));
        // full boost gain against hard steps
        add_cfg(CFG_BOOST_FACTOR, 32'h0000_7FFF);
        add_item(mk(MODE_STAB, 32767, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(MODE_STAB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_item(mk(MODE_SPORT, -32768, -32768, -32768, -16384, -16384, -16384, 0, 0, 0, 0));
        add_item(mk(MODE_SPORT, -32768, -32768, -32768, -16384, -16384, -16384, 0, 0, 0, 0));
        add_item(mk(MODE_MANUAL, 0, 0, 0, 16384, 16384, 16384, 16384, 0, 0, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                drain();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                i_cfg_we <= 1'b0;
                send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
            end
        end
        n_directed = n_items;

        last_it = '0;
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 56;
            end else if (seg < 4) begin
                send_idle_pct = 56;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            apply_segment_config(seg);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                // repeat an input now and then so the boost sees steady levels
                if (n > 0 && $urandom_range(3) == 0) it = last_it;
                else it = rand_item();
                last_it = it;
                send_item(it, 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Drove %0d transactions (%0d directed) through %0d register writes",
                 n_items, n_directed, n_writes);
        $display("and three handshake pressure profiles; %0d results seen, %0d mismatches.",
                 n_results, err_count);
        if (err_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
